/* rtl/generational_handle_allocator_macros.svh */
// Assertion macros for the generational handle allocator.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define GHA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("generational_handle_allocator: assertion failed");

// Next-cycle implication.
`define GHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("generational_handle_allocator: assertion failed");

`endif

/* rtl/gha_pkg.sv */
// Shared types and codes for the generational handle allocator.
// No dependencies; imported by gha_check and the top level.
package gha_pkg;

  localparam int HandleW = 32;
  localparam int AllocIdW = 6;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [HandleW-1:0] handle;
  } gha_in_t;

  typedef struct packed {
    logic [HandleW-1:0] new_handle;
    logic [1:0]         status;
  } gha_out_t;

endpackage

/* rtl/gha_check.sv */
// Handle decoder and liveness check for the generational handle allocator.
// Depends on gha_pkg for the handle width.
module gha_check import gha_pkg::*; #(
  parameter int INDEX_BITS     = 10,
  parameter int VERSION_BITS   = 16,
  parameter int ALLOCATOR_BITS = 6
) (
  input  logic [HandleW-1:0]        handle_i,
  input  logic [VERSION_BITS:0]     slot_i,
  input  logic [INDEX_BITS:0]       issued_count_i,
  input  logic [ALLOCATOR_BITS-1:0] alloc_id_i,
  output logic                      live_o,
  output logic [INDEX_BITS-1:0]     idx_o,
  output logic [VERSION_BITS-1:0]   ver_o
);

  localparam int HW = INDEX_BITS + VERSION_BITS + ALLOCATOR_BITS;
  localparam int EXT_W = (HW > HandleW) ? HW : HandleW;
  localparam int VER_SHIFT = INDEX_BITS;
  localparam int ALC_SHIFT = INDEX_BITS + VERSION_BITS;
  localparam logic [EXT_W-1:0] NULL_EXT = EXT_W'({HW{1'b1}});

  logic [EXT_W-1:0]          h_ext;
  logic [ALLOCATOR_BITS-1:0] alc;
  logic                      issued;
  logic                      is_null;

  // Bits of a field that lie above the handle width read as zero.
  assign h_ext   = EXT_W'(handle_i);
  assign idx_o   = h_ext[INDEX_BITS-1:0];
  assign ver_o   = h_ext[VER_SHIFT +: VERSION_BITS];
  assign alc     = h_ext[ALC_SHIFT +: ALLOCATOR_BITS];
  assign issued  = {1'b0, idx_o} < issued_count_i;
  assign is_null = handle_i == NULL_EXT[HandleW-1:0];

  assign live_o = issued && !is_null && (alc == alloc_id_i) &&
                  slot_i[VERSION_BITS] && (slot_i[VERSION_BITS-1:0] == ver_o);

endmodule

/* rtl/generational_handle_allocator.sv */
// Generational handle allocator: issues, releases and checks 32-bit handles
// that pack slot index (low bits), version and allocator id (top field).
// Input channel in_valid_i/in_ready_o carries op and handle; output channel
// out_valid_o/out_ready_i carries new_handle and status, one result per item.
// Op allocate pops the most recently released handle or issues a fresh
// index with version 0; release frees a live handle and queues it with the
// next version; query reports whether a handle is live.
// Operands and the top of the free stack are read synchronously on the
// input transfer; the execute step then writes back and registers the
// result, and no new item is accepted until that write-back is done.
// A stalled receiver holds the block in its write-back step until the
// pending result is taken; no new item is accepted meanwhile.
// cfg_we_i/cfg_wdata_i write the allocator id; write it only while idle.
// Reset empties the free stack and the issued count and clears the id;
// no clearing pass is needed since memory entries are read only after
// they have been written.
// Depends on gha_pkg, gha_check and generational_handle_allocator_macros.svh.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int INDEX_BITS     = 10,
  parameter int VERSION_BITS   = 16,
  parameter int ALLOCATOR_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [AllocIdW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gha_in_t             in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gha_out_t            out_o
);

  localparam int SLOT_COUNT = 1 << INDEX_BITS;
  localparam int HW = INDEX_BITS + VERSION_BITS + ALLOCATOR_BITS;
  localparam int EXT_W = (HW > HandleW) ? HW : HandleW;
  localparam int SLOT_W = VERSION_BITS + 1;
  localparam int STACK_W = INDEX_BITS + VERSION_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  gha_in_t                   req_q;
  logic [AllocIdW-1:0]       alloc_id_q;
  logic [INDEX_BITS:0]       issued_count_q, issued_count_d;
  logic [INDEX_BITS:0]       free_depth_q, free_depth_d;
  logic                      out_valid_q;
  gha_out_t                  out_q, out_d;

  logic [SLOT_W-1:0]         slot_mem [SLOT_COUNT];
  logic [STACK_W-1:0]        stack_mem [SLOT_COUNT];
  logic [SLOT_W-1:0]         slot_rdata_q;
  logic [STACK_W-1:0]        stack_rdata_q;

  logic                      slot_we, stack_we;
  logic [INDEX_BITS-1:0]     slot_waddr, stack_waddr;
  logic [SLOT_W-1:0]         slot_wdata;
  logic [STACK_W-1:0]        stack_wdata;

  logic                      in_fire, exec_fire;
  logic [ALLOCATOR_BITS-1:0] alc_id;
  logic                      live;
  logic [INDEX_BITS-1:0]     chk_idx, pop_idx;
  logic [VERSION_BITS-1:0]   chk_ver, pop_ver;

  function automatic logic [HandleW-1:0] make_handle(input logic [INDEX_BITS-1:0] idx,
                                                     input logic [VERSION_BITS-1:0] ver,
                                                     input logic [ALLOCATOR_BITS-1:0] alc);
    logic [EXT_W-1:0] h;
    h = EXT_W'({alc, ver, idx});
    return h[HandleW-1:0];
  endfunction

  assign in_ready_o  = state_q == S_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign exec_fire   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign alc_id      = ALLOCATOR_BITS'(alloc_id_q);
  assign pop_idx     = stack_rdata_q[INDEX_BITS-1:0];
  assign pop_ver     = stack_rdata_q[INDEX_BITS +: VERSION_BITS];

  gha_check #(
    .INDEX_BITS     (INDEX_BITS),
    .VERSION_BITS   (VERSION_BITS),
    .ALLOCATOR_BITS (ALLOCATOR_BITS)
  ) u_check (
    .handle_i       (req_q.handle),
    .slot_i         (slot_rdata_q),
    .issued_count_i (issued_count_q),
    .alloc_id_i     (alc_id),
    .live_o         (live),
    .idx_o          (chk_idx),
    .ver_o          (chk_ver)
  );

  // Write-back step: one write per memory at most.
  always_comb begin
    state_d        = state_q;
    issued_count_d = issued_count_q;
    free_depth_d   = free_depth_q;
    out_d          = '{new_handle: '0, status: ST_INVALID};
    slot_we        = 1'b0;
    slot_waddr     = chk_idx;
    slot_wdata     = '0;
    stack_we       = 1'b0;
    stack_waddr    = free_depth_q[INDEX_BITS-1:0];
    stack_wdata    = {chk_ver + VERSION_BITS'(1), chk_idx};

    case (req_q.op)
      OP_ALLOC: begin
        if (free_depth_q != '0) begin
          slot_waddr       = pop_idx;
          slot_wdata       = {1'b1, pop_ver};
          slot_we          = 1'b1;
          free_depth_d     = free_depth_q - (INDEX_BITS + 1)'(1);
          out_d.new_handle = make_handle(pop_idx, pop_ver, alc_id);
          out_d.status     = ST_OK;
        end else if (!issued_count_q[INDEX_BITS]) begin
          slot_waddr       = issued_count_q[INDEX_BITS-1:0];
          slot_wdata       = {1'b1, {VERSION_BITS{1'b0}}};
          slot_we          = 1'b1;
          issued_count_d   = issued_count_q + (INDEX_BITS + 1)'(1);
          out_d.new_handle = make_handle(issued_count_q[INDEX_BITS-1:0], '0, alc_id);
          out_d.status     = ST_OK;
        end else begin
          out_d.status = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        if (live) begin
          if (!free_depth_q[INDEX_BITS]) begin
            stack_we     = 1'b1;
            free_depth_d = free_depth_q + (INDEX_BITS + 1)'(1);
          end
          slot_we      = 1'b1;
          out_d.status = ST_OK;
        end
      end
      OP_QUERY: begin
        out_d.status = live ? ST_OK : ST_INVALID;
      end
      default: begin
        out_d.status = ST_INVALID;
      end
    endcase

    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hold all state while the pending result is not yet taken.
    if (!exec_fire) begin
      issued_count_d = issued_count_q;
      free_depth_d   = free_depth_q;
      slot_we        = 1'b0;
      stack_we       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      issued_count_q <= '0;
      free_depth_q   <= '0;
      alloc_id_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      issued_count_q <= issued_count_d;
      free_depth_q   <= free_depth_d;
      if (cfg_we_i) alloc_id_q <= cfg_wdata_i;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_i;
    if (exec_fire) out_q <= out_d;
  end

  // Slot table: live bit above the current version.
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (in_fire) slot_rdata_q <= slot_mem[in_i.handle[INDEX_BITS-1:0]];
  end

  // Free stack: read the top entry on every transfer; used only by allocate.
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (in_fire) begin
      stack_rdata_q <= stack_mem[free_depth_q[INDEX_BITS-1:0] - INDEX_BITS'(1)];
    end
  end

`include "generational_handle_allocator_macros.svh"

  `GHA_ASSERT_IMPL(a_depth_le_issued, 1'b1, free_depth_q <= issued_count_q)
  `GHA_ASSERT_IMPL(a_issued_bound, 1'b1, issued_count_q <= (INDEX_BITS + 1)'(SLOT_COUNT))
  `GHA_ASSERT_NEXT(a_accept_exec, in_fire, state_q == S_EXEC)
  `GHA_ASSERT_IMPL(a_fail_zero, out_valid_q && (out_q.status != ST_OK), out_q.new_handle == '0)

endmodule

/* test/tb_generational_handle_allocator.sv */
// Self-checking testbench for generational_handle_allocator: an in-bench predictor
// tracks the slot table, free stack and allocator id and checks every result in order.
// Depends on gha_pkg and the RTL of the block; needs no files or arguments.
module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int IdxW = 10;
  localparam int VerW = 16;
  localparam int SlotN = 1 << IdxW;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [HandleW-1:0] NULL_HANDLE = '1;

  typedef struct packed {
    logic [AllocIdW-1:0] aid;
    logic [VerW-1:0]     ver;
    logic [IdxW-1:0]     idx;
  } handle_t;

  typedef struct packed {
    logic [VerW-1:0] ver;
    logic [IdxW-1:0] idx;
  } free_ent_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [AllocIdW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  gha_in_t             in_item = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  gha_out_t            out_item;

  // Predicted allocator state
  logic                slot_live [SlotN];
  logic [VerW-1:0]     slot_ver [SlotN];
  free_ent_t           free_stk [SlotN];
  int unsigned         issued_n = 0;
  int unsigned         free_n = 0;
  logic [AllocIdW-1:0] alloc_id = '0;
  int                  live_idx_q[$];
  gha_out_t            pending_replies[$];

  int  fail_count = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  bit  pace_en = 1'b1;
  bit  rx_stall_en = 1'b1;

  generational_handle_allocator #(
    .INDEX_BITS     (IdxW),
    .VERSION_BITS   (VerW),
    .ALLOCATOR_BITS (AllocIdW)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_item)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [HandleW-1:0] make_handle(input logic [AllocIdW-1:0] aid,
                                                     input logic [VerW-1:0] ver,
                                                     input logic [IdxW-1:0] idx);
    return {aid, ver, idx};
  endfunction

  function automatic bit handle_is_live(input logic [HandleW-1:0] h);
    handle_t hf;
    hf = h;
    if (hf.idx >= issued_n) return 1'b0;
    if (h == NULL_HANDLE) return 1'b0;
    if (hf.aid != alloc_id) return 1'b0;
    return slot_live[hf.idx] && slot_ver[hf.idx] == hf.ver;
  endfunction

  function automatic void drop_live_index(input int idx);
    for (int i = 0; i < live_idx_q.size(); i++) begin
      if (live_idx_q[i] == idx) begin
        live_idx_q.delete(i);
        return;
      end
    end
  endfunction

  // Advance the predicted state by one request and return the reply it gives
  function automatic gha_out_t allocator_reply(input gha_in_t item);
    gha_out_t  r;
    handle_t   hf;
    free_ent_t e;
    r.new_handle = '0;
    r.status = ST_INVALID;
    hf = item.handle;
    case (item.op)
      OP_ALLOC: begin
        if (free_n > 0) begin
          free_n--;
          e = free_stk[free_n];
          slot_live[e.idx] = 1'b1;
          slot_ver[e.idx] = e.ver;
          live_idx_q.push_back(int'(e.idx));
          r.new_handle = make_handle(alloc_id, e.ver, e.idx);
          r.status = ST_OK;
        end else if (issued_n < SlotN) begin
          slot_live[issued_n] = 1'b1;
          slot_ver[issued_n] = '0;
          live_idx_q.push_back(int'(issued_n));
          r.new_handle = make_handle(alloc_id, '0, issued_n[IdxW-1:0]);
          issued_n++;
          r.status = ST_OK;
        end else begin
          r.status = ST_EXHAUSTED;
        end
      end
      OP_RELEASE: begin
        if (handle_is_live(item.handle)) begin
          if (free_n < SlotN) begin
            e.idx = hf.idx;
            e.ver = hf.ver + VerW'(1);
            free_stk[free_n] = e;
            free_n++;
          end
          slot_live[hf.idx] = 1'b0;
          drop_live_index(int'(hf.idx));
          r.status = ST_OK;
        end
      end
      OP_QUERY: begin
        if (handle_is_live(item.handle)) r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [HandleW-1:0] h);
    gha_in_t item;
    item.op = op;
    item.handle = h;
    if (pace_en) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_item <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_replies.push_back(allocator_reply(item));
  endtask

  task automatic wait_replies_drained();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_allocator_id(input logic [AllocIdW-1:0] id);
    wait_replies_drained();
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    alloc_id = id;
  endtask

  // Mostly well-formed traffic on live handles, plus stale, corrupted and junk handles
  task automatic send_random_item();
    int unsigned        pick;
    int                 idx;
    logic [VerW-1:0]    dv;
    logic [HandleW-1:0] h;
    logic [1:0]         op;
    pick = $urandom_range(0, 99);
    op = ($urandom_range(0, 1) == 0) ? OP_RELEASE : OP_QUERY;
    h = $urandom;
    if (pick < 35) begin
      op = OP_ALLOC;
    end else if (pick < 83 && live_idx_q.size() != 0) begin
      idx = live_idx_q[$urandom_range(0, live_idx_q.size() - 1)];
      h = make_handle(alloc_id, slot_ver[idx], IdxW'(idx));
      if (pick < 60) op = OP_RELEASE;
      else if (pick < 72) op = OP_QUERY;
      else h[$urandom_range(0, HandleW - 1)] ^= 1'b1;
    end else if (pick < 90 && issued_n != 0) begin
      idx = $urandom_range(0, issued_n - 1);
      dv = VerW'($urandom_range(0, 2));
      h = make_handle(alloc_id, slot_ver[idx] - dv, IdxW'(idx));
    end else if (pick < 95) begin
      op = 2'($urandom_range(0, 3));
    end else if (pick < 98) begin
      h = NULL_HANDLE;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, h);
  endtask

  task automatic test_directed();
    write_allocator_id('0);
    send_item(OP_QUERY, '0);                         // nothing issued yet
    send_item(OP_ALLOC, NULL_HANDLE);                // handle field ignored
    send_item(OP_ALLOC, '0);
    send_item(OP_QUERY, make_handle('0, '0, 0));
    send_item(OP_QUERY, make_handle('0, '0, 5));     // index beyond issued count
    send_item(OP_RELEASE, NULL_HANDLE);
    send_item(OP_QUERY, NULL_HANDLE);
    send_item(OP_UNUSED, make_handle('0, '0, 0));
    send_item(OP_RELEASE, make_handle('0, '0, 0));
    send_item(OP_QUERY, make_handle('0, '0, 0));     // stale version
    send_item(OP_RELEASE, make_handle('0, '0, 0));   // double release
    send_item(OP_ALLOC, '0);                         // reuse with bumped version
    send_item(OP_QUERY, make_handle(1, 1, 0));       // wrong allocator
    send_item(OP_QUERY, make_handle('0, 1, 0));
    send_item(OP_RELEASE, make_handle('0, '0, 1));
    send_item(OP_RELEASE, make_handle('0, 1, 0));
    send_item(OP_ALLOC, '0);                         // last freed comes back first
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);                         // fresh index
    send_item(OP_UNUSED, NULL_HANDLE);
    write_allocator_id('1);
    send_item(OP_QUERY, make_handle('1, 2, 0));
    send_item(OP_QUERY, make_handle('0, 2, 0));
    send_item(OP_RELEASE, make_handle('1, 1, 1));
  endtask

  task automatic test_random(input logic [AllocIdW-1:0] id, input int n);
    write_allocator_id(id);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        pace_en = $urandom_range(0, 3) != 0;
        rx_stall_en = $urandom_range(0, 3) != 0;
      end
      if (i == n / 2) wait_replies_drained();
      send_random_item();
    end
    pace_en = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  task automatic test_exhaustion();
    while (free_n != 0 || issued_n < SlotN) send_item(OP_ALLOC, $urandom);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, NULL_HANDLE);
    send_item(OP_QUERY, make_handle(alloc_id, slot_ver[SlotN-1], IdxW'(SlotN - 1)));
  endtask

  // Cycle the top slot through a few versions under the all-ones id, where the
  // null handle stays invalid, then free and reissue it under another id.
  task automatic test_slot_recycle();
    pace_en = 1'b0;
    rx_stall_en = 1'b0;
    write_allocator_id('1);
    repeat (4) begin
      send_item(OP_RELEASE, make_handle(alloc_id, slot_ver[SlotN-1], IdxW'(SlotN - 1)));
      send_item(OP_ALLOC, '0);
    end
    send_item(OP_QUERY, NULL_HANDLE);
    send_item(OP_RELEASE, NULL_HANDLE);
    write_allocator_id(6'd5);
    send_item(OP_RELEASE, make_handle(alloc_id, slot_ver[SlotN-1], IdxW'(SlotN - 1)));
    send_item(OP_ALLOC, '0);
    send_item(OP_QUERY, make_handle(alloc_id, slot_ver[SlotN-1], IdxW'(SlotN - 1)));
    pace_en = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  always @(posedge clk_i) begin : reply_check
    gha_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: new_handle %h status %0d",
                   out_item.new_handle, out_item.status);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_item.new_handle !== want.new_handle || out_item.status !== want.status) begin
          if (fail_count < 10)
            $display("mismatch: new_handle %h status %0d, expected new_handle %h status %0d",
                     out_item.new_handle, out_item.status, want.new_handle, want.status);
          fail_count++;
        end
      end
    end
    if (rx_stall_en && stall_left == 0 && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(6'($urandom_range(1, 62)), 60);
    test_random('1, 40);
    test_exhaustion();
    test_slot_recycle();
    test_random(6'($urandom_range(1, 62)), 50);
    test_random('0, 30);
    wait_replies_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
